@@ design/sbsa_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsa_pkg
// Types and constants shared by the slot bitmap scan allocator.
// ----------------------------------------------------------------------------
package sbsa_pkg;

    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 7'd127;
    localparam logic [COUNT_W-1:0] COUNT_ZERO = 7'd0;
    localparam logic [COUNT_W-1:0] COUNT_ONE  = 7'd1;

    typedef enum logic [1:0] {
        REQ_NEXT  = 2'd0,
        REQ_PREV  = 2'd1,
        REQ_ALLOC = 2'd2,
        REQ_FREE  = 2'd3
    } req_kind_t;

    typedef struct packed {
        req_kind_t          req_type;
        logic [SLOT_W-1:0]  slot_index;
    } req_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  result_slot;
        logic               found;
        logic [COUNT_W-1:0] used_count;
    } rsp_t;

endpackage

@@ design/slot_bitmap_scan_allocator.sv @@
// ----------------------------------------------------------------------------
// slot_bitmap_scan_allocator
// Occupancy bitmap with circular next/previous scans, lowest-free allocate
// and free, with a saturating count of used slots.
// ----------------------------------------------------------------------------
//  channel | valid      | stall      | word
//  request | req_valid  | req_stall  | req_word (req_type, slot_index)
//  result  | rsp_valid  | rsp_stall  | rsp_word (result_slot, found, used_count)
//
// One request per cycle sustained while rsp_stall is low; a result word is
// loaded into the result register from its request in the input register.
// The map update for one request lands in the same edge that loads its result,
// so the next request already sees it.
// Reset clears the map, the count and both valid flags at once.
// rsp_stall holds the result register; the input register then fills and
// req_stall rises.
// ----------------------------------------------------------------------------
module slot_bitmap_scan_allocator #(
    parameter int NUM_SLOTS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sbsa_pkg::req_t req_word,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sbsa_pkg::rsp_t rsp_word
);

    logic                         in_valid_reg, in_valid_next;
    sbsa_pkg::req_t               in_word_reg;
    logic                         out_valid_reg, out_valid_next;
    sbsa_pkg::rsp_t               out_word_reg;
    logic [NUM_SLOTS-1:0]         map_reg, map_next;
    logic [sbsa_pkg::COUNT_W-1:0] count_reg, count_next;

    logic                         out_free;
    logic                         fire;
    sbsa_pkg::rsp_t               core_rsp;
    logic [NUM_SLOTS-1:0]         core_map;
    logic [sbsa_pkg::COUNT_W-1:0] core_count;

    sbsa_core #(.NUM_SLOTS(NUM_SLOTS)) u_core (
        .map        (map_reg),
        .count      (count_reg),
        .req        (in_word_reg),
        .rsp        (core_rsp),
        .map_next   (core_map),
        .count_next (core_count)
    );

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign fire      = in_valid_reg && out_free;
    assign req_stall = in_valid_reg && !out_free;

    always_comb
    begin
        in_valid_next  = req_stall ? in_valid_reg : req_valid;
        out_valid_next = out_free ? fire : out_valid_reg;
        map_next       = fire ? core_map : map_reg;
        count_next     = fire ? core_count : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            map_reg       <= '0;
            count_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            map_reg       <= map_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!req_stall)
        begin
            in_word_reg <= req_word;
        end
        if (fire)
        begin
            out_word_reg <= core_rsp;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_word  = out_word_reg;

endmodule

@@ design/sbsa_ffs.sv @@
// ----------------------------------------------------------------------------
// sbsa_ffs
// Find first set: isolates the lowest set bit and encodes its position.
// ----------------------------------------------------------------------------
module sbsa_ffs #(
    parameter int N     = 64,
    parameter int IDX_W = 6
) (
    input  logic [N-1:0]     bits,
    output logic             any,
    output logic [IDX_W-1:0] index
);

    logic [N-1:0] first;

    assign any   = |bits;
    // two's complement trick keeps only the lowest set bit
    assign first = bits & (~bits + N'(1));

    always_comb
    begin
        index = '0;
        for (int i = 0; i < N; i++)
        begin
            index = index | (first[i] ? IDX_W'(i) : '0);
        end
    end

endmodule

@@ design/sbsa_core.sv @@
// ----------------------------------------------------------------------------
// sbsa_core
// Single-pass request logic: circular scans, allocate and free against the
// occupancy map, plus the used-slot count update.
// ----------------------------------------------------------------------------
module sbsa_core #(
    parameter int NUM_SLOTS = 64
) (
    input  logic [NUM_SLOTS-1:0]       map,
    input  logic [sbsa_pkg::COUNT_W-1:0] count,
    input  sbsa_pkg::req_t             req,
    output sbsa_pkg::rsp_t             rsp,
    output logic [NUM_SLOTS-1:0]       map_next,
    output logic [sbsa_pkg::COUNT_W-1:0] count_next
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EXT_W = (IDX_W > sbsa_pkg::SLOT_W) ? IDX_W : sbsa_pkg::SLOT_W;
    localparam logic [EXT_W-1:0] TOP_SLOT = EXT_W'(NUM_SLOTS - 1);

    logic                 in_range;
    logic [NUM_SLOTS-1:0] ge_mask;
    logic [NUM_SLOTS-1:0] le_mask;
    logic [NUM_SLOTS-1:0] clr_vec;
    logic [NUM_SLOTS-1:0] alloc_vec;
    logic [NUM_SLOTS-1:0] next_masked;
    logic [NUM_SLOTS-1:0] prev_masked_rev;
    logic [NUM_SLOTS-1:0] map_rev;
    logic [NUM_SLOTS-1:0] free_vec;

    logic                 nm_any, na_any, pm_any, pa_any, fr_any;
    logic [EXT_W-1:0]     nm_idx, na_idx, pm_idx, pa_idx, fr_idx;
    logic [EXT_W-1:0]     pm_slot, pa_slot;

    logic [sbsa_pkg::COUNT_W-1:0] count_inc;
    logic [sbsa_pkg::COUNT_W-1:0] count_dec;

    assign in_range = int'(req.slot_index) < NUM_SLOTS;

    // out-of-range start: next scans from slot 0, previous from the top slot,
    // so both masks open fully
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            ge_mask[i]   = !in_range || (i >= int'(req.slot_index));
            le_mask[i]   = !in_range || (i <= int'(req.slot_index));
            clr_vec[i]   = (i == int'(req.slot_index));
            alloc_vec[i] = (i == int'(fr_idx));
        end
    end

    assign next_masked = map & ge_mask;
    assign free_vec    = ~map;

    // downward scans run through copies of the same encoder on bit-reversed vectors
    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            prev_masked_rev[i] = map[NUM_SLOTS-1-i] & le_mask[NUM_SLOTS-1-i];
            map_rev[i]         = map[NUM_SLOTS-1-i];
        end
    end

    sbsa_ffs #(.N(NUM_SLOTS), .IDX_W(EXT_W)) u_next_masked (
        .bits(next_masked), .any(nm_any), .index(nm_idx)
    );
    sbsa_ffs #(.N(NUM_SLOTS), .IDX_W(EXT_W)) u_next_all (
        .bits(map), .any(na_any), .index(na_idx)
    );
    sbsa_ffs #(.N(NUM_SLOTS), .IDX_W(EXT_W)) u_prev_masked (
        .bits(prev_masked_rev), .any(pm_any), .index(pm_idx)
    );
    sbsa_ffs #(.N(NUM_SLOTS), .IDX_W(EXT_W)) u_prev_all (
        .bits(map_rev), .any(pa_any), .index(pa_idx)
    );
    sbsa_ffs #(.N(NUM_SLOTS), .IDX_W(EXT_W)) u_alloc (
        .bits(free_vec), .any(fr_any), .index(fr_idx)
    );

    assign pm_slot = TOP_SLOT - pm_idx;
    assign pa_slot = TOP_SLOT - pa_idx;

    assign count_inc = (count == sbsa_pkg::COUNT_MAX) ? count : count + sbsa_pkg::COUNT_ONE;
    assign count_dec = (count == sbsa_pkg::COUNT_ZERO) ? count : count - sbsa_pkg::COUNT_ONE;

    always_comb
    begin
        rsp.result_slot = '0;
        rsp.found       = 1'b0;
        map_next        = map;
        count_next      = count;
        unique case (req.req_type)
            sbsa_pkg::REQ_NEXT:
            begin
                if (nm_any)
                begin
                    rsp.result_slot = nm_idx[sbsa_pkg::SLOT_W-1:0];
                    rsp.found       = 1'b1;
                end
                else if (na_any)
                begin
                    rsp.result_slot = na_idx[sbsa_pkg::SLOT_W-1:0];
                    rsp.found       = 1'b1;
                end
            end
            sbsa_pkg::REQ_PREV:
            begin
                rsp.result_slot = TOP_SLOT[sbsa_pkg::SLOT_W-1:0];
                if (pm_any)
                begin
                    rsp.result_slot = pm_slot[sbsa_pkg::SLOT_W-1:0];
                    rsp.found       = 1'b1;
                end
                else if (pa_any)
                begin
                    rsp.result_slot = pa_slot[sbsa_pkg::SLOT_W-1:0];
                    rsp.found       = 1'b1;
                end
            end
            sbsa_pkg::REQ_ALLOC:
            begin
                if (fr_any)
                begin
                    rsp.result_slot = fr_idx[sbsa_pkg::SLOT_W-1:0];
                    rsp.found       = 1'b1;
                    map_next        = map | alloc_vec;
                    count_next      = count_inc;
                end
            end
            sbsa_pkg::REQ_FREE:
            begin
                rsp.result_slot = req.slot_index;
                map_next        = map & ~clr_vec;
                count_next      = count_dec;
            end
        endcase
        rsp.used_count = count_next;
    end

endmodule

@@ design/sbsa_check.sv @@
// ----------------------------------------------------------------------------
// sbsa_check
// Port-level checks for the slot bitmap scan allocator.
// ----------------------------------------------------------------------------
module sbsa_check (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input sbsa_pkg::req_t req_word,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sbsa_pkg::rsp_t rsp_word
);

    // held result word stays put
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("result word changed while stalled");

    // stalled request word stays put
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
        else $error("request word changed while stalled");

    // result valid is cleared by reset
    a_rst_idle: assert property (@(posedge clk) !rst_n |-> !rsp_valid)
        else $error("result valid during reset");

    // request side only backs up when the result register is full and held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("request stall without a held result");

    // back-to-back results change the count by at most one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall) ##1 rsp_valid |->
            (rsp_word.used_count == $past(rsp_word.used_count)) ||
            (rsp_word.used_count == $past(rsp_word.used_count) + 7'd1) ||
            (rsp_word.used_count == $past(rsp_word.used_count) - 7'd1))
        else $error("used count jumped");

endmodule

bind slot_bitmap_scan_allocator sbsa_check u_sbsa_check (.*);
